/* hw/rtl/crfr_pkg.sv */
package crfr_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int STORE_BYTES = FRAME_BYTES - 2;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam logic [7:0] HEADER_BYTE = 8'h46;

    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);

    localparam logic [1:0] ST_VALID     = 2'd0;
    localparam logic [1:0] ST_CSUM_ERR  = 2'd1;
    localparam logic [1:0] ST_RESET_CMD = 2'd2;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [1:0] status;
        t_byte      command;
        t_byte      aux_order;
        t_byte      data_byte0;
        t_byte      data_byte1;
        t_byte      data_byte2;
        t_byte      data_byte3;
    } t_result;

    // expected frame text F(RESET)
    function automatic t_byte reset_text(input logic [POS_W-1:0] pos);
        t_byte b;
        case (pos)
            3'd0:    b = 8'h46;
            3'd1:    b = 8'h28;
            3'd2:    b = 8'h52;
            3'd3:    b = 8'h45;
            3'd4:    b = 8'h53;
            3'd5:    b = 8'h45;
            3'd6:    b = 8'h54;
            3'd7:    b = 8'h29;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/crfr_if.sv */
interface crfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_in_burst;

    modport source (output valid, output rx_byte, output last_in_burst, input ready);
    modport sink   (input valid, input rx_byte, input last_in_burst, output ready);
endinterface

interface crfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] command;
    logic [7:0] aux_order;
    logic [7:0] data_byte0;
    logic [7:0] data_byte1;
    logic [7:0] data_byte2;
    logic [7:0] data_byte3;

    modport source (output valid, output status, output command, output aux_order,
                    output data_byte0, output data_byte1, output data_byte2,
                    output data_byte3, input ready);
    modport sink   (input valid, input status, input command, input aux_order,
                    input data_byte0, input data_byte1, input data_byte2,
                    input data_byte3, output ready);
endinterface

interface crfr_cfg_if;
    logic valid;
    logic ready;
    logic unit_off;

    modport source (output valid, output unit_off, input ready);
    modport sink   (input valid, input unit_off, output ready);
endinterface

/* hw/rtl/crfr_framer.sv */
module crfr_framer
    import crfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_byte   i_rx_byte,
    input  logic    i_last_in_burst,
    input  logic    i_unit_off,
    output logic    o_at_last,
    output logic    o_res_valid,
    output t_result o_res
);

    logic             r_in_frame;
    logic [POS_W-1:0] r_pos;
    t_byte            r_sum;
    logic             r_match;
    t_byte            r_store [STORE_BYTES];

    logic             n_in_frame;
    logic [POS_W-1:0] n_pos;
    t_byte            n_sum;
    logic             n_match;
    logic             store_we;
    logic [POS_W-1:0] store_idx;
    logic             final_match;

    assign o_at_last   = r_in_frame && (r_pos == POS_LAST);
    assign o_res_valid = i_accept && o_at_last;
    assign store_idx   = r_pos - POS_FIRST;
    assign final_match = r_match && (i_rx_byte == reset_text(POS_LAST));

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_match    = r_match;
        store_we   = 1'b0;
        if (i_accept) begin
            if (!r_in_frame) begin
                if (i_rx_byte == HEADER_BYTE && !i_last_in_burst) begin
                    n_in_frame = 1'b1;
                    n_pos      = POS_FIRST;
                    n_sum      = i_rx_byte;
                    n_match    = 1'b1;
                end
            end else if (r_pos != POS_LAST) begin
                store_we = 1'b1;
                n_sum    = r_sum + i_rx_byte;
                n_pos    = r_pos + POS_FIRST;
                if (i_rx_byte != reset_text(r_pos)) begin
                    n_match = 1'b0;
                end
                // burst ended mid-frame: drop it
                if (i_last_in_burst) begin
                    n_in_frame = 1'b0;
                    n_pos      = '0;
                    n_sum      = '0;
                end
            end else begin
                n_match    = final_match;
                n_in_frame = 1'b0;
                n_pos      = '0;
                n_sum      = '0;
            end
        end
    end

    always_comb begin
        o_res.command    = r_store[0];
        o_res.aux_order  = r_store[1];
        o_res.data_byte0 = r_store[2];
        o_res.data_byte1 = r_store[3];
        o_res.data_byte2 = r_store[4];
        o_res.data_byte3 = r_store[5];
        if (r_sum == i_rx_byte) begin
            o_res.status = ST_VALID;
        end else if (i_unit_off && final_match) begin
            o_res.status = ST_RESET_CMD;
        end else begin
            o_res.status = ST_CSUM_ERR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_sum      <= '0;
            r_match    <= 1'b1;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_match    <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_idx] <= i_rx_byte;
        end
    end

endmodule

/* hw/rtl/checksummed_frame_receiver_core.sv */
// output: the result appears in the output register in the cycle after the
// frame's eighth byte is accepted
// throughput: one byte per cycle; the eighth byte of a frame waits only while
// a previous result is still held in the output register and not taken
// reset (synchronous, active low): hunting for header, unit_off cleared
module checksummed_frame_receiver_core
    import crfr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    crfr_in_if.sink    i_in,
    crfr_out_if.source o_out,
    crfr_cfg_if.sink   i_cfg
);

    logic    r_unit_off;
    logic    r_out_valid;
    t_result r_out;

    logic    in_accept;
    logic    at_last;
    logic    res_valid;
    t_result res;

    // only the frame's final byte needs room in the output register
    assign i_in.ready = !r_out_valid || o_out.ready || !at_last;
    assign in_accept  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    crfr_framer u_framer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_rx_byte       (i_in.rx_byte),
        .i_last_in_burst (i_in.last_in_burst),
        .i_unit_off      (r_unit_off),
        .o_at_last       (at_last),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_off  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_unit_off <= i_cfg.unit_off;
            end
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out.status;
    assign o_out.command    = r_out.command;
    assign o_out.aux_order  = r_out.aux_order;
    assign o_out.data_byte0 = r_out.data_byte0;
    assign o_out.data_byte1 = r_out.data_byte1;
    assign o_out.data_byte2 = r_out.data_byte2;
    assign o_out.data_byte3 = r_out.data_byte3;

endmodule
